@@ sv/csr_pkg.sv @@
// Package for the compressed sparse row matrix store.
// Holds the payload beat types, size constants, mode and status codes; no dependencies.
package csr_pkg;
    localparam int ROWS_DEF        = 64;
    localparam int COLS_DEF        = 64;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [63:0] wr_value;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] rd_value;
        logic        found;
        logic [1:0]  status;
        logic [8:0]  entry_count;
    } t_out_beat;
endpackage

@@ sv/csr_sparse_matrix_store.sv @@
// Compressed sparse row matrix store: one access (read, write, remove) per input beat.
// An access reads the row's bounds, scans its entries by column, then acts; an insert or
// a remove also shifts the later entries and adjusts every following row start. An access
// whose row or column is out of range skips straight to the result.
// Throughput: one access at a time; o_ready returns the cycle after the result beat is taken.
// Synchronous active-low reset, then a pass over all ROWS + 1 row starts zeroes them. Uses csr_pkg.
module csr_sparse_matrix_store #(
    parameter int ROWS        = csr_pkg::ROWS_DEF,
    parameter int COLS        = csr_pkg::COLS_DEF,
    parameter int MAX_ENTRIES = csr_pkg::MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  csr_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output csr_pkg::t_out_beat o_data
);
    localparam int RW = $clog2(ROWS + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_END, S_CMP, S_ACT, S_SHUP, S_SHDN, S_ROWS, S_FIN
    } t_state;

    t_state             r_state;
    csr_pkg::t_in_beat  r_req;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_pos, r_end, r_idx;
    logic [RW-1:0]      r_k;
    logic               r_found;
    logic [63:0]        r_rd;
    logic [1:0]         r_status;
    logic               r_valid;
    csr_pkg::t_out_beat r_out;

    // Row starts and entries live in memories with one registered read port each.
    logic [CW-1:0] r_rs [ROWS+1];
    logic [CW-1:0] r_rs_q;
    logic [5:0]    r_mcol [MAX_ENTRIES];
    logic [63:0]   r_mval [MAX_ENTRIES];
    logic [5:0]    r_qcol;
    logic [63:0]   r_qval;

    logic          n_rs_we;
    logic [RW-1:0] n_rs_waddr, n_rs_raddr;
    logic [CW-1:0] n_rs_wd;
    logic          n_m_we;
    logic [AW-1:0] n_m_waddr, n_m_raddr;
    logic [5:0]    n_m_wcol;
    logic [63:0]   n_m_wval;

    logic          in_range;
    logic [RW-1:0] row_next;
    assign in_range = (32'(i_data.row) < ROWS) && (32'(i_data.col) < COLS);
    assign row_next = RW'(r_req.row) + RW'(1);

    always_ff @(posedge i_clk) begin
        if (n_rs_we) r_rs[n_rs_waddr] <= n_rs_wd;
        r_rs_q <= r_rs[n_rs_raddr];
        if (n_m_we) begin
            r_mcol[n_m_waddr] <= n_m_wcol;
            r_mval[n_m_waddr] <= n_m_wval;
        end
        r_qcol <= r_mcol[n_m_raddr];
        r_qval <= r_mval[n_m_raddr];
    end

    // Memory address and write controls follow the sequencer state. Reads are issued in the
    // cycle before the write that uses them, so each shift or row start update moves one entry per cycle.
    always_comb begin
        n_rs_we    = 1'b0;
        n_rs_waddr = r_k;
        n_rs_raddr = row_next;
        n_rs_wd    = '0;
        n_m_we     = 1'b0;
        n_m_waddr  = r_idx[AW-1:0];
        n_m_raddr  = r_pos[AW-1:0];
        n_m_wcol   = r_qcol;
        n_m_wval   = r_qval;
        unique case (r_state)
            S_CLEAR: n_rs_we = 1'b1;
            S_IDLE:  n_rs_raddr = RW'(i_data.row);
            S_CMP:   n_m_raddr = r_pos[AW-1:0] + AW'(1);
            S_ACT: begin
                if (r_req.mode == csr_pkg::MODE_WRITE && r_found) begin
                    n_m_we    = 1'b1;
                    n_m_waddr = r_pos[AW-1:0];
                    n_m_wcol  = r_req.col;
                    n_m_wval  = r_req.wr_value;
                end
                n_m_raddr = (r_req.mode == csr_pkg::MODE_REMOVE) ? r_pos[AW-1:0] + AW'(1)
                                                                  : r_count[AW-1:0] - AW'(1);
            end
            S_SHUP: begin
                n_m_we    = 1'b1;
                n_m_raddr = r_idx[AW-1:0] - AW'(2);
                if (r_idx == r_pos) begin
                    n_m_wcol = r_req.col;
                    n_m_wval = r_req.wr_value;
                end
            end
            S_SHDN: begin
                n_m_we    = (r_idx + CW'(1)) < r_count;
                n_m_raddr = r_idx[AW-1:0] + AW'(2);
            end
            S_ROWS: begin
                n_rs_we    = 1'b1;
                n_rs_raddr = (r_k == RW'(ROWS)) ? r_k : r_k + RW'(1);
                n_rs_wd    = (r_req.mode == csr_pkg::MODE_WRITE) ? r_rs_q + CW'(1)
                                                                  : r_rs_q - CW'(1);
            end
            default: ;
        endcase
    end

    // Sequencer: scan the row, act, on insert or remove shift entries, fix later row starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + RW'(1);
                    if (r_k == RW'(ROWS)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid && o_ready) begin
                    r_req    <= i_data;
                    r_found  <= 1'b0;
                    r_rd     <= '0;
                    r_status <= (!in_range && i_data.mode == csr_pkg::MODE_REMOVE)
                                ? csr_pkg::ST_MISSING : csr_pkg::ST_OK;
                    r_state  <= in_range ? S_START : S_FIN;
                end
                S_START: begin
                    r_pos   <= r_rs_q;
                    r_state <= S_END;
                end
                S_END: begin
                    r_end   <= (r_rs_q > r_count) ? r_count : r_rs_q;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // Column of entry r_pos arrives this cycle.
                    if (r_pos >= r_end) begin
                        r_state <= S_ACT;
                    end else if (r_req.col > r_qcol) begin
                        r_pos <= r_pos + CW'(1);
                    end else begin
                        if (r_qcol == r_req.col) begin
                            r_found <= 1'b1;
                            r_rd    <= r_qval;
                        end
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    r_k <= row_next;
                    priority if (r_req.mode == csr_pkg::MODE_WRITE) begin
                        if (r_found) begin
                            r_state <= S_FIN;
                        end else if (r_count >= CW'(MAX_ENTRIES)) begin
                            r_status <= csr_pkg::ST_FULL;
                            r_state  <= S_FIN;
                        end else begin
                            r_idx   <= r_count;
                            r_state <= S_SHUP;
                        end
                    end else if (r_req.mode == csr_pkg::MODE_REMOVE) begin
                        if (!r_found) begin
                            r_status <= csr_pkg::ST_MISSING;
                            r_state  <= S_FIN;
                        end else begin
                            r_idx   <= r_pos;
                            r_state <= S_SHDN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SHUP: begin
                    if (r_idx == r_pos) begin
                        r_state <= S_ROWS;
                    end else begin
                        r_idx <= r_idx - CW'(1);
                    end
                end
                S_SHDN: begin
                    if ((r_idx + CW'(1)) >= r_count) begin
                        r_state <= S_ROWS;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_ROWS: begin
                    r_k <= r_k + RW'(1);
                    if (r_k == RW'(ROWS)) begin
                        r_count <= (r_req.mode == csr_pkg::MODE_WRITE) ? r_count + CW'(1)
                                                                        : r_count - CW'(1);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out.rd_value    <= r_rd;
                    r_out.found       <= r_found;
                    r_out.status      <= r_status;
                    r_out.entry_count <= 9'(r_count);
                    r_state           <= S_IDLE;
                end
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data));
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid);
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES));
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_pos <= r_end));
endmodule
